// ----- rtl/pulse_beat_detector_top_macros.svh -----
// Assertion macros used by the beat detector top level
`ifndef PULSE_BEAT_DETECTOR_TOP_MACROS_SVH
`define PULSE_BEAT_DETECTOR_TOP_MACROS_SVH

// Check cons in the same cycle as ante, outside reset
`define PBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse beat detector check failed");

// Check cons in the cycle after ante, outside reset
`define PBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse beat detector check failed");

`endif

// ----- rtl/pbd_pkg.sv -----
// Types and constants for the pulse beat detector
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int SUM_W    = 18;
  localparam int INDEX_W  = 8;

  // Register indexes of the configuration port
  localparam logic [INDEX_W-1:0] REG_MIN_AMPLITUDE = 8'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_AMPLITUDE = 8'd1;

  // Reset values
  localparam logic [CFG_W-1:0]           MIN_AMPLITUDE_RST = 16'd20;
  localparam logic [CFG_W-1:0]           MAX_AMPLITUDE_RST = 16'd3000;
  localparam logic signed [SAMPLE_W-1:0] PEAK_RST          = 16'sd20;
  localparam logic signed [SAMPLE_W-1:0] TROUGH_RST        = -16'sd20;

  // Largest average the leaky sum can reach
  localparam logic [CFG_W-1:0] AVG_MAX = 16'd65534;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic             beat;
    logic [CFG_W-1:0] avg_amplitude;
  } result_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_amplitude;
    logic [CFG_W-1:0] max_amplitude;
  } cfg_t;

endpackage

// ----- rtl/pbd_stream_if.sv -----
// Valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface pbd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pbd_cfg_regs.sv -----
// Configuration registers for the amplitude window
`timescale 1ns / 1ps

module pbd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pbd_pkg::INDEX_W-1:0]   wr_index,
  input  logic [pbd_pkg::CFG_W-1:0]     wr_data,
  output pbd_pkg::cfg_t                 cfg
);
  import pbd_pkg::*;

  // Decode writes; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_amplitude <= MIN_AMPLITUDE_RST;
      cfg.max_amplitude <= MAX_AMPLITUDE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MIN_AMPLITUDE: cfg.min_amplitude <= wr_data;
        REG_MAX_AMPLITUDE: cfg.max_amplitude <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pbd_core.sv -----
// Peak/trough tracker, beat decision and leaky amplitude sum
`timescale 1ns / 1ps

module pbd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  pbd_pkg::sample_item_t item,
  input  pbd_pkg::cfg_t         cfg,
  output pbd_pkg::result_item_t result
);
  import pbd_pkg::*;

  logic                       rising;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic signed [SAMPLE_W-1:0] cycle_peak;
  logic signed [SAMPLE_W-1:0] cycle_trough;
  logic [SUM_W-1:0]           amplitude_sum;

  logic                       rising_next;
  logic signed [SAMPLE_W-1:0] cycle_peak_next;
  logic signed [SAMPLE_W-1:0] cycle_trough_next;
  logic [SUM_W-1:0]           amplitude_sum_next;

  logic                       up;
  logic                       down;
  logic                       turn_fall;
  logic                       turn_rise;
  logic signed [SAMPLE_W:0]   amp;
  logic                       beat;
  logic signed [SAMPLE_W-1:0] peak_upd;
  logic signed [SAMPLE_W-1:0] trough_upd;

  // Compare against the previous sample and find the turns
  always_comb begin
    up        = item.sample > previous_sample;
    down      = item.sample < previous_sample;
    turn_fall = rising && down;
    turn_rise = !rising && up;
  end

  // Track peak while rising, trough while falling
  always_comb begin
    peak_upd   = (rising && up) ? item.sample : cycle_peak;
    trough_upd = (!rising && down) ? item.sample : cycle_trough;
  end

  // Amplitude of the finished cycle and the window test
  always_comb begin
    amp  = {cycle_peak[SAMPLE_W-1], cycle_peak} - {cycle_trough[SAMPLE_W-1], cycle_trough};
    beat = turn_fall
        && (amp > $signed({1'b0, cfg.min_amplitude}))
        && (amp < $signed({1'b0, cfg.max_amplitude}));
  end

  // Next state
  always_comb begin
    cycle_trough_next  = turn_fall ? '0 : trough_upd;
    cycle_peak_next    = turn_rise ? '0 : peak_upd;
    rising_next        = turn_fall ? 1'b0 : (turn_rise ? 1'b1 : rising);
    amplitude_sum_next = amplitude_sum;
    if (beat) begin
      amplitude_sum_next = amplitude_sum - (amplitude_sum >> 2)
                         + {{(SUM_W-SAMPLE_W){1'b0}}, amp[SAMPLE_W-1:0]};
    end
  end

  // Result for this sample
  always_comb begin
    result.beat          = beat;
    result.avg_amplitude = amplitude_sum_next[SUM_W-1:2];
  end

  // Hold state; advance on each processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      rising          <= 1'b0;
      previous_sample <= '0;
      cycle_peak      <= PEAK_RST;
      cycle_trough    <= TROUGH_RST;
      amplitude_sum   <= '0;
    end else if (advance) begin
      rising          <= rising_next;
      previous_sample <= item.sample;
      cycle_peak      <= cycle_peak_next;
      cycle_trough    <= cycle_trough_next;
      amplitude_sum   <= amplitude_sum_next;
    end
  end

endmodule

// ----- rtl/pulse_beat_detector_top.sv -----
// Top level of the pulse beat detector
//
//   channel   dir  payload                         handshake
//   samples   in   sample (s16)                    valid/ready
//   results   out  beat (1), avg_amplitude (u16)   valid/ready
//   wr_*      in   min/max amplitude (u16)         write enable only
//
// One sample per cycle while results are taken; a sample passes through the input
// register, then the result register. The tracker state updates
// in the cycle that moves a sample from the input register to the result
// register. Reset is synchronous and restores the default window and state.
// A stalled result holds in its register while one more sample can be taken.
`timescale 1ns / 1ps
`include "pulse_beat_detector_top_macros.svh"

module pulse_beat_detector_top (
  input  logic                        clk,
  input  logic                        rst,
  pbd_stream_if.sink                  samples,
  pbd_stream_if.source                results,
  input  logic                        wr_en,
  input  logic [pbd_pkg::INDEX_W-1:0] wr_index,
  input  logic [pbd_pkg::CFG_W-1:0]   wr_data
);
  import pbd_pkg::*;

  cfg_t         cfg;
  logic         in_valid;
  sample_item_t in_item;
  logic         out_valid;
  result_item_t out_item;
  result_item_t core_result;
  logic         out_free;
  logic         advance;

  pbd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  pbd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Flow control between the two register stages
  always_comb begin
    out_free      = !out_valid || results.ready;
    advance       = in_valid && out_free;
    samples.ready = !in_valid || out_free;
    results.valid = out_valid;
    results.data  = out_item;
  end

  // Input register: load on transfer, drop when the sample moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_item <= samples.data;
    end
  end

  // Result register: load on advance, drop on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  // A sample stuck behind a stalled result keeps its place
  `PBD_ASSERT_NEXT(a_in_hold, in_valid && !out_free, in_valid && $stable(in_item))
  // Every processed sample lands in the result register
  `PBD_ASSERT_NEXT(a_advance_result, advance, out_valid)
  // The leaky sum never grows past its bound
  `PBD_ASSERT_SAME(a_avg_bound, out_valid, out_item.avg_amplitude <= AVG_MAX)

endmodule
